>>> rtl/gswg_pkg.sv
// Shared types, constants and codes of the Gold sequence word generator.
`timescale 1ns / 1ps
package gswg_pkg;

  localparam int SKIP_WORDS  = 50;
  localparam int CELL_WORDS  = 14;
  localparam int PORT5_WORDS = 38;
  localparam int MAX_RESULTS = 38;

  localparam int CELL_RUN   = (CELL_WORDS > MAX_RESULTS) ? MAX_RESULTS : CELL_WORDS;
  localparam int PORT5_RUN  = (PORT5_WORDS > MAX_RESULTS) ? MAX_RESULTS : PORT5_WORDS;
  localparam int SKIP_STEPS = (SKIP_WORDS > 1) ? SKIP_WORDS - 1 : 0;
  localparam int CNT_MAX    = (SKIP_STEPS > MAX_RESULTS) ? SKIP_STEPS : MAX_RESULTS;
  localparam int CNT_W      = $clog2(CNT_MAX + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ID_W       = 9;
  localparam int RNTI_W     = 16;
  localparam int WORD_W     = 32;
  localparam int INDEX_W    = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELL_ID      = 3'd0,
    CFG_CP_EXTENDED  = 3'd1,
    CFG_USE_DMRS_IDS = 3'd2,
    CFG_DMRS_ID_ZERO = 3'd3,
    CFG_DMRS_ID_ONE  = 3'd4,
    CFG_RNTI         = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_CELL_REF = 2'd0,
    OP_UE_SPEC  = 2'd1,
    OP_PORT5    = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [4:0] slot;
    logic       pilot_symbol;
    logic       scrambling_select;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0]  seq_word;
    logic [INDEX_W-1:0] word_index;
    logic               last;
  } res_t;

  typedef struct packed {
    logic               capture;
    logic               load;
    logic               step;
    logic               emit;
    logic               last;
    logic [INDEX_W-1:0] index;
  } cmd_t;

endpackage

>>> rtl/gswg_ctrl.sv
// Sequencing state machine: load, skip and emit phases of one item.
`timescale 1ns / 1ps
module gswg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [1:0]        opcode_i,
  output logic              busy,
  output gswg_pkg::cmd_t    cmd_o
);
  import gswg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_SKIP = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] words_q, words_d;
  logic [CNT_W-1:0] run_words;
  logic             op_ok;

  always_comb begin
    case (opcode_i)
      OP_CELL_REF, OP_UE_SPEC: begin
        op_ok     = 1'b1;
        run_words = CNT_W'(CELL_RUN);
      end
      OP_PORT5: begin
        op_ok     = 1'b1;
        run_words = CNT_W'(PORT5_RUN);
      end
      default: begin
        op_ok     = 1'b0;
        run_words = '0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    words_d     = words_q;
    cmd_o       = '0;
    cmd_o.index = INDEX_W'(cnt_q);
    case (state_q)
      S_IDLE: begin
        if (start && op_ok && (run_words != '0)) begin
          cmd_o.capture = 1'b1;
          words_d       = run_words;
          state_d       = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        cnt_d      = '0;
        state_d    = (SKIP_STEPS > 0) ? S_SKIP : S_EMIT;
      end
      S_SKIP: begin
        cmd_o.step = 1'b1;
        if (cnt_q == CNT_W'(SKIP_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_EMIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_EMIT: begin
        cmd_o.step = 1'b1;
        cmd_o.emit = 1'b1;
        cmd_o.last = (cnt_q == words_q - 1'b1);
        cnt_d      = cnt_q + 1'b1;
        if (cmd_o.last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      words_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      words_q <= words_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  a_last_is_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.last |-> cmd_o.emit)
    else $error("last flag outside emit phase");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.last) |=> (state_q == S_IDLE))
    else $error("run continues after last word");

  a_index_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (cnt_q < words_q))
    else $error("word index beyond run length");

  a_load_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |-> $past(cmd_o.capture))
    else $error("load without accepted item");

endmodule

>>> rtl/gswg_dp.sv
// Datapath: configuration registers, start value, LFSR pair and result register.
`timescale 1ns / 1ps
module gswg_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gswg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gswg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  gswg_pkg::req_t                 req_i,
  input  gswg_pkg::cmd_t                 cmd_i,
  output logic                           result_valid_o,
  output gswg_pkg::res_t                 result_o
);
  import gswg_pkg::*;

  logic [ID_W-1:0]   cell_id_q, dmrs_id_zero_q, dmrs_id_one_q;
  logic              cp_extended_q, use_dmrs_ids_q;
  logic [RNTI_W-1:0] rnti_q;

  logic [9:0]  fa_q, fa_d;
  logic [7:0]  fb_q, fb_d;
  logic [15:0] add_q, add_d;
  logic        sh16_q, sh16_d;

  logic [WORD_W-1:0] x1_q, x1_d, x2_q, x2_d;
  logic [17:0]       prod;
  logic [WORD_W-1:0] cinit;
  logic [ID_W-1:0]   nid;
  logic [2:0]        sym;
  logic [7:0]        slot_term;

  logic   valid_q;
  res_t   res_q;

  function automatic logic [WORD_W-1:0] adv_x1(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] p;
    p = (v >> 1) ^ (v >> 4);
    return p ^ (p << 31) ^ (p << 28);
  endfunction

  function automatic logic [WORD_W-1:0] adv_x2(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] q;
    q = (v >> 1) ^ (v >> 2) ^ (v >> 3) ^ (v >> 4);
    return q ^ (q << 31) ^ (q << 30) ^ (q << 29) ^ (q << 28);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_id_q      <= '0;
      cp_extended_q  <= 1'b0;
      use_dmrs_ids_q <= 1'b0;
      dmrs_id_zero_q <= '0;
      dmrs_id_one_q  <= '0;
      rnti_q         <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CELL_ID:      cell_id_q      <= cfg_wdata_i[ID_W-1:0];
        CFG_CP_EXTENDED:  cp_extended_q  <= cfg_wdata_i[0];
        CFG_USE_DMRS_IDS: use_dmrs_ids_q <= cfg_wdata_i[0];
        CFG_DMRS_ID_ZERO: dmrs_id_zero_q <= cfg_wdata_i[ID_W-1:0];
        CFG_DMRS_ID_ONE:  dmrs_id_one_q  <= cfg_wdata_i[ID_W-1:0];
        CFG_RNTI:         rnti_q         <= cfg_wdata_i[RNTI_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sym       = req_i.pilot_symbol ? (cp_extended_q ? 3'd3 : 3'd4) : 3'd0;
    slot_term = 8'd7 * (8'(req_i.slot) + 8'd1);
    if (use_dmrs_ids_q) begin
      nid = req_i.scrambling_select ? dmrs_id_one_q : dmrs_id_zero_q;
    end else begin
      nid = cell_id_q;
    end
    fa_d   = fa_q;
    fb_d   = fb_q;
    add_d  = add_q;
    sh16_d = sh16_q;
    if (cmd_i.capture) begin
      case (req_i.opcode)
        OP_CELL_REF: begin
          fa_d   = {cell_id_q, 1'b1};
          fb_d   = 8'd1 + 8'(sym) + slot_term;
          add_d  = 16'({cell_id_q, 1'b0}) + 16'(!cp_extended_q);
          sh16_d = 1'b0;
        end
        OP_UE_SPEC: begin
          fa_d   = {nid, 1'b1};
          fb_d   = 8'(req_i.slot[4:1]) + 8'd1;
          add_d  = 16'(req_i.scrambling_select);
          sh16_d = 1'b1;
        end
        default: begin
          fa_d   = {cell_id_q, 1'b1};
          fb_d   = 8'(req_i.slot[4:1]) + 8'd1;
          add_d  = rnti_q;
          sh16_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    fa_q   <= fa_d;
    fb_q   <= fb_d;
    add_q  <= add_d;
    sh16_q <= sh16_d;
  end

  always_comb begin
    prod  = 18'(fa_q) * 18'(fb_q);
    cinit = (sh16_q ? (WORD_W'(prod) << 16) : (WORD_W'(prod) << 10)) + WORD_W'(add_q);
    cinit[WORD_W-1] = cinit[0] ^ cinit[1] ^ cinit[2] ^ cinit[3];
    x1_d = x1_q;
    x2_d = x2_q;
    if (cmd_i.load) begin
      x1_d = 32'h8000_0001;
      x2_d = cinit;
    end else if (cmd_i.step) begin
      x1_d = adv_x1(x1_q);
      x2_d = adv_x2(x2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q <= x1_d;
    x2_q <= x2_d;
    if (cmd_i.emit) begin
      res_q.seq_word   <= x1_d ^ x2_d;
      res_q.word_index <= cmd_i.index;
      res_q.last       <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule

>>> rtl/gold_sequence_word_generator.sv
// Top level of the Gold sequence word generator.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------
//  request  | start, busy (taken if !busy)| req_i   (opcode, slot, ...)
//  config   | cfg_we_i, cfg_idx_i         | cfg_wdata_i (16 bits)
//  result   | result_valid_o (one cycle)  | result_o (seq_word, index, last)
//
// An item runs through acceptance, a load, SKIP_WORDS - 1 skip steps and N words,
// N = 14 or 38, with one 32-bit step of the LFSR pair per cycle.
// The first word appears after the skip steps, then one per cycle.
// Reset clears the configuration registers to zero and returns the sequencer to idle.
// Results cannot be stalled; a new item may be taken while the last word is shown.
`timescale 1ns / 1ps
module gold_sequence_word_generator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gswg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gswg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           start,
  output logic                           busy,
  input  gswg_pkg::req_t                 req_i,
  output logic                           result_valid_o,
  output gswg_pkg::res_t                 result_o
);
  import gswg_pkg::*;

  cmd_t cmd;

  gswg_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (req_i.opcode),
    .busy     (busy),
    .cmd_o    (cmd)
  );

  gswg_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_i          (req_i),
    .cmd_i          (cmd),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
